>>> design/b3cw_pkg.sv
// Shared constants, types and register codes of the center-weighted 3x3 blur.
`default_nettype none
package b3cw_pkg;

  localparam int PIX_W          = 8;
  localparam int SUM_W          = 12;
  localparam int CENTER_EXTRA   = 7;
  localparam int NORM_SHIFT     = 4;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT     = 4096;
  localparam int MIN_SIZE       = 3;

  localparam int CFG_WIDTH_W    = 9;
  localparam int CFG_HEIGHT_W   = 13;
  localparam int ROW_W          = 13;
  localparam int WIDTH_RESET    = 256;
  localparam int HEIGHT_RESET   = 251;

  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic   shift;
    pixel_t top;
    pixel_t mid;
    pixel_t px;
  } win_in_t;

  typedef struct packed {
    pixel_t center_prev;
    pixel_t blur;
  } win_out_t;

endpackage : b3cw_pkg
`default_nettype wire

>>> design/blur_3x3_center_weighted.sv
// Top level of the center-weighted 3x3 blur over a raster pixel stream.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid / in_ready   | in_mode, in_pixel_in
//  out      | output    | out_valid / out_ready | out_pixel_out, out_frame_last
//  config   | input     | psel/penable/pready   | paddr, pwdata, prdata
//
// One item per clock while in_ready is high; its result is registered in the
// cycle after acceptance, one line plus one pixel of items later in the stream.
// Every cell of the two line chains and the window shift together in the
// cycle an item is taken, so the rate is set by the window adder alone.
// Synchronous active-low reset clears the counters, window and output valid.
// in_ready drops only while a result waits and out_ready is low.
`default_nettype none
module blur_3x3_center_weighted
  import b3cw_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Pixel input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_mode,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  // Result output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PIX_W-1:0]           out_pixel_out,
  output logic                       out_frame_last,
  // Configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int IW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;

  // Configuration registers, kept raw for read back.
  logic [CFG_WIDTH_W-1:0]  width_raw_r,  width_raw_nxt;
  logic [CFG_HEIGHT_W-1:0] height_raw_r, height_raw_nxt;

  // Stream position of the next input item.
  logic [IW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Output register.
  logic   out_valid_r, out_valid_nxt;
  pixel_t out_pix_r,   out_pix_nxt;
  logic   out_last_r,  out_last_nxt;

  logic             cfg_wr;
  logic [CMPW-1:0]  width_ext;
  logic [CMPW-1:0]  w_use;
  logic [IW-1:0]    w_m1;
  logic [ROW_W-1:0] h_use;
  logic             fire;
  logic             in_frame;
  logic             step;
  logic             has_out;
  logic             interior;
  logic             last;
  pixel_t           px_eff;
  pixel_t           mid_q;
  pixel_t           top_q;
  win_in_t          win_in;
  win_out_t         win_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_raw_r);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_raw_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    width_raw_nxt  = width_raw_r;
    height_raw_nxt = height_raw_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  width_raw_nxt  = pwdata[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_raw_nxt = pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range.
  always_comb begin
    width_ext = CMPW'(width_raw_r);
    if (width_ext < CMPW'(MIN_SIZE)) begin
      w_use = CMPW'(MIN_SIZE);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      w_use = CMPW'(MAX_WIDTH);
    end else begin
      w_use = width_ext;
    end
    if (height_raw_r < CFG_HEIGHT_W'(MIN_SIZE)) begin
      h_use = ROW_W'(MIN_SIZE);
    end else if (height_raw_r > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      h_use = ROW_W'(MAX_HEIGHT);
    end else begin
      h_use = ROW_W'(height_raw_r);
    end
  end

  assign w_m1 = IW'(w_use - CMPW'(1));

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign in_frame = row_r < h_use;
  // Drop a flush tick while frame pixels are still expected.
  assign step     = fire && !(in_mode && in_frame);
  // Past the last pixel every item drains; feed zeros.
  assign px_eff   = in_frame ? in_pixel_in : '0;

  // The first line and one pixel produce no result.
  assign has_out  = !((row_r == '0) || ((row_r == ROW_W'(1)) && (col_r == '0)));
  assign interior = (col_r >= IW'(2)) && (row_r >= ROW_W'(2)) && in_frame;
  assign last     = (row_r == h_use + ROW_W'(1)) && (col_r == '0);

  b3cw_line #(.DEPTH(MAX_WIDTH)) u_line_mid (
    .clk      (clk),
    .shift_en (step),
    .len_m1   (w_m1),
    .data_in  (px_eff),
    .data_out (mid_q)
  );

  b3cw_line #(.DEPTH(MAX_WIDTH)) u_line_top (
    .clk      (clk),
    .shift_en (step),
    .len_m1   (w_m1),
    .data_in  (mid_q),
    .data_out (top_q)
  );

  assign win_in.shift = step;
  assign win_in.top   = top_q;
  assign win_in.mid   = mid_q;
  assign win_in.px    = px_eff;

  b3cw_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .win_in  (win_in),
    .win_out (win_out)
  );

  // Advance the stream position; restart on frame end or any register write.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (step) begin
      if (has_out && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == w_m1) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + IW'(1);
      end
    end
  end

  // Border pixels pass through: the center before the shift is the pixel due.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step && has_out) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = interior ? win_out.blur : win_out.center_prev;
      out_last_nxt  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= CFG_WIDTH_W'(WIDTH_RESET);
      height_raw_r <= CFG_HEIGHT_W'(HEIGHT_RESET);
      col_r        <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      width_raw_r  <= width_raw_nxt;
      height_raw_r <= height_raw_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r  <= out_pix_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pix_r;
  assign out_frame_last = out_last_r;

endmodule : blur_3x3_center_weighted
`default_nettype wire

>>> design/b3cw_cell.sv
// One cell of a line-store chain: loads the new pixel or takes its neighbor's.
`default_nettype none
module b3cw_cell
  import b3cw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   shift_en,
  input  wire logic   load_sel,
  input  wire pixel_t load_data,
  input  wire pixel_t neighbor_data,
  output pixel_t      q
);

  pixel_t q_r;
  pixel_t q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (shift_en) begin
      q_nxt = load_sel ? load_data : neighbor_data;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule : b3cw_cell
`default_nettype wire

>>> design/b3cw_line.sv
// Line store as a chain of cells with a programmable entry point.
`default_nettype none
module b3cw_line
  import b3cw_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF
)(
  input  wire logic                     clk,
  input  wire logic                     shift_en,
  input  wire logic [$clog2(DEPTH)-1:0] len_m1,
  input  wire pixel_t                   data_in,
  output pixel_t                        data_out
);

  localparam int IW = $clog2(DEPTH);

  pixel_t cell_q [DEPTH];

  // Enter at cell len_m1, move toward cell 0: delay equals the line length.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IW-1:0] POS = IW'(i);
    pixel_t nb;
    if (i == DEPTH - 1) begin : g_end
      assign nb = data_in;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    b3cw_cell u_cell (
      .clk           (clk),
      .shift_en      (shift_en),
      .load_sel      (len_m1 == POS),
      .load_data     (data_in),
      .neighbor_data (nb),
      .q             (cell_q[i])
    );
  end

  assign data_out = cell_q[0];

endmodule : b3cw_line
`default_nettype wire

>>> design/b3cw_window.sv
// 3x3 window registers and the center-weighted sum.
`default_nettype none
module b3cw_window
  import b3cw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire win_in_t win_in,
  output win_out_t     win_out
);

  pixel_t win_r   [3][3];
  pixel_t win_nxt [3][3];
  logic [SUM_W-1:0] sum;

  always_comb begin
    win_nxt = win_r;
    if (win_in.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r][0] = win_r[r][1];
        win_nxt[r][1] = win_r[r][2];
      end
      win_nxt[0][2] = win_in.top;
      win_nxt[1][2] = win_in.mid;
      win_nxt[2][2] = win_in.px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else begin
      win_r <= win_nxt;
    end
  end

  // Sum over the shifted window; its center is the current right middle cell.
  always_comb begin
    sum = SUM_W'(win_r[0][1]) + SUM_W'(win_r[0][2]) + SUM_W'(win_in.top)
        + SUM_W'(win_r[1][1]) + SUM_W'(win_r[1][2]) + SUM_W'(win_in.mid)
        + SUM_W'(win_r[2][1]) + SUM_W'(win_r[2][2]) + SUM_W'(win_in.px)
        + SUM_W'(CENTER_EXTRA) * SUM_W'(win_r[1][2]);
  end

  assign win_out.blur        = PIX_W'(sum >> NORM_SHIFT);
  assign win_out.center_prev = win_r[1][2];

endmodule : b3cw_window
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the center-weighted 3x3 blur: directed table, then random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b3cw_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  // The result is registered on acceptance; leave some margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 180;
  localparam int TALL_ITEMS    = 200;
  localparam int MAX_PRINTED   = 40;
  localparam int SMALL_SIDE    = 12;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

  typedef struct packed {
    pixel_t pix;
    logic   frame_last;
  } blurred_t;

  // One row of the directed part. When known is set, the row's result is
  // typed in here instead of taken from the predictor.
  typedef struct packed {
    logic   mode;
    pixel_t pix;
    logic   known;
    pixel_t want_pix;
    logic   want_last;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 16;

  // 3x3 frame: flush ticks that arrive while pixels are still due are
  // dropped, borders pass through, the center is blurred, a pixel item
  // during drain acts as a flush tick, and the final drain tick flags the
  // end of the frame. A flush right after that belongs to a new frame and
  // is dropped again.
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{MODE_FLUSH, 8'h5A, 1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd0,  1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd255,1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd17, 1'b0, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'h33, 1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd128,1'b0, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd255,1'b1, 8'd0,   1'b0},
    '{MODE_PIXEL, 8'd1,  1'b1, 8'd255, 1'b0},
    '{MODE_PIXEL, 8'd200,1'b1, 8'd17,  1'b0},
    '{MODE_PIXEL, 8'd64, 1'b1, 8'd128, 1'b0},
    '{MODE_PIXEL, 8'd99, 1'b0, 8'd0,   1'b0},
    '{MODE_FLUSH, 8'h00, 1'b1, 8'd1,   1'b0},
    '{MODE_PIXEL, 8'hAA, 1'b1, 8'd200, 1'b0},
    '{MODE_FLUSH, 8'hFF, 1'b1, 8'd64,  1'b0},
    '{MODE_FLUSH, 8'h00, 1'b1, 8'd99,  1'b1},
    '{MODE_FLUSH, 8'h77, 1'b0, 8'd0,   1'b0}
  };

  // DUT connections; the inputs are driven to known values from time zero.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  in_mode     = 1'b0;
  pixel_t                in_pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  pixel_t                out_pixel_out;
  logic                  out_frame_last;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: registers, line stores, window and stream counters.
  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  pixel_t                  upper_line  [MAX_WIDTH_DEF];
  pixel_t                  middle_line [MAX_WIDTH_DEF];
  pixel_t                  win_regs    [3][3];
  logic [8:0]              col_ctr;
  logic [ROW_W-1:0]        row_ctr;
  logic [20:0]             out_ctr;

  blurred_t    blurred_q [$];
  int          mismatch_count = 0;
  int unsigned stream_items   = 0;
  int unsigned cycle_count    = 0;
  int          tx_idle_pct    = 0;
  int          rx_stall_pct   = 0;
  blurred_t    seen;

  blur_3x3_center_weighted uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: end the run as a mismatch once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("blur_3x3_center_weighted: mismatch");
      $finish;
    end
  end

  // Receiver: stall at random with the current phase's rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Result checker: compare every accepted item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (blurred_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result pixel %0d last %0b",
                                  out_pixel_out, out_frame_last));
      end else begin
        seen = blurred_q.pop_front();
        if (out_pixel_out !== seen.pix)
          report_mismatch($sformatf("pixel_out %0d, want %0d", out_pixel_out, seen.pix));
        if (out_frame_last !== seen.frame_last)
          report_mismatch($sformatf("frame_last %0b, want %0b", out_frame_last,
                                    seen.frame_last));
      end
    end
  end

  function automatic int unsigned eff_width();
    if (cfg_width < MIN_SIZE) return MIN_SIZE;
    if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < MIN_SIZE) return MIN_SIZE;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  function automatic void restart_frame_ctrs();
    col_ctr = '0;
    row_ctr = '0;
    out_ctr = '0;
  endfunction

  // Advance the blur by one accepted item; return 1 when the item
  // completes an output pixel, with that pixel in res_pix/res_last.
  function automatic logic blur_step(input logic mode, input pixel_t pix_in,
                                     output pixel_t res_pix, output logic res_last);
    int unsigned w, h, total, n, c, orow, ocol, sum;
    int          r, k;
    pixel_t      px, top, mid, corner;
    w        = eff_width();
    h        = eff_height();
    total    = w * h;
    n        = row_ctr * w + col_ctr;
    res_pix  = '0;
    res_last = 1'b0;
    // Drop flush ticks while pixels of the frame are still due.
    if (mode == MODE_FLUSH && n < total) return 1'b0;
    // During drain the pixel is discarded and zeros shift in.
    px     = (n < total) ? pix_in : '0;
    c      = col_ctr;
    top    = upper_line[c];
    mid    = middle_line[c];
    corner = upper_line[w - 1];
    upper_line[c]  = mid;
    middle_line[c] = px;
    for (r = 0; r < 3; r++) begin
      win_regs[r][0] = win_regs[r][1];
      win_regs[r][1] = win_regs[r][2];
    end
    win_regs[0][2] = top;
    win_regs[1][2] = mid;
    win_regs[2][2] = px;
    col_ctr = col_ctr + 1;
    if (col_ctr >= w) begin
      col_ctr = '0;
      row_ctr = row_ctr + 1;
    end
    if (n < w + 1) return 1'b0;
    // Column zero completes the last pixel of the row two above.
    if (c == 0) begin
      orow    = n / w - 2;
      ocol    = w - 1;
      res_pix = corner;
    end else begin
      orow    = n / w - 1;
      ocol    = c - 1;
      res_pix = win_regs[1][1];
    end
    if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
      sum = 0;
      for (r = 0; r < 3; r++)
        for (k = 0; k < 3; k++)
          sum += win_regs[r][k];
      sum += CENTER_EXTRA * win_regs[1][1];
      res_pix = pixel_t'(sum >> NORM_SHIFT);
    end
    res_last = (out_ctr + 1 >= total);
    out_ctr  = out_ctr + 1;
    if (res_last) restart_frame_ctrs();
    return 1'b1;
  endfunction

  // Offer one item, wait for the handshake, then step the predictor.
  task automatic push_item(input logic mode, input pixel_t pix, input logic known,
                           input pixel_t want_pix, input logic want_last);
    pixel_t res_pix;
    logic   res_last;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_pixel_in <= pix;
    do @(posedge clk); while (!in_ready);
    if (blur_step(mode, pix, res_pix, res_last)) begin
      if (known) blurred_q.push_back('{want_pix, want_last});
      else blurred_q.push_back('{res_pix, res_last});
    end
  endtask

  // Drop valid, drain every expected item, then give in-flight work time.
  task automatic settle();
    in_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the
  // edge where pready is high. Any write restarts the frame.
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_FRAME_WIDTH) cfg_width = data[CFG_WIDTH_W-1:0];
    else cfg_height = data[CFG_HEIGHT_W-1:0];
    restart_frame_ctrs();
    @(posedge clk);
  endtask

  task automatic cfg_check(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register at %0d reads %0d, want %0d", addr, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input int wval, input int hval, input logic wr_w,
                           input logic wr_h);
    settle();
    if (wr_w) cfg_write(ADDR_FRAME_WIDTH, wval);
    if (wr_h) cfg_write(ADDR_FRAME_HEIGHT, hval);
    cfg_check(ADDR_FRAME_WIDTH, cfg_width);
    cfg_check(ADDR_FRAME_HEIGHT, cfg_height);
  endtask

  // Send one frame plus its drain ticks, cut short after stop_at items.
  // Sprinkle dropped flush ticks into the pixel part and pixel items
  // into the drain.
  task automatic send_frame(input int unsigned stop_at);
    int unsigned w, pixels, span, k;
    w      = eff_width();
    pixels = w * eff_height();
    span   = pixels + w + 1;
    for (k = 0; k < span && k < stop_at; k++) begin
      if (k < pixels) begin
        if ($urandom_range(99) < 4)
          push_item(MODE_FLUSH, pixel_t'($urandom_range(255)), 1'b0, '0, 1'b0);
        push_item(MODE_PIXEL, pixel_t'($urandom_range(255)), 1'b0, '0, 1'b0);
      end else begin
        push_item(($urandom_range(99) < 20) ? MODE_PIXEL : MODE_FLUSH,
                  pixel_t'($urandom_range(255)), 1'b0, '0, 1'b0);
      end
      stream_items++;
    end
  endtask

  initial begin
    int          phase, sel, wval, hval, nframes, f;
    int unsigned phase_start, span;
    logic        cut;

    // Predictor reset mirrors the block's reset.
    cfg_width  = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++)
        win_regs[r][k] = '0;
    restart_frame_ctrs();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: reset values, then the hand-checked 3x3 frame.
    cfg_check(ADDR_FRAME_WIDTH, WIDTH_RESET);
    cfg_check(ADDR_FRAME_HEIGHT, HEIGHT_RESET);
    set_frame(3, 3, 1'b1, 1'b1);
    foreach (directed[i])
      push_item(directed[i].mode, directed[i].pix, directed[i].known,
                directed[i].want_pix, directed[i].want_last);

    // Random part in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 29;
          rx_stall_pct = 45;
          // all-zero registers clamp up to the smallest frame
          set_frame(0, 0, 1'b1, 1'b1);
        end
        1: begin
          tx_idle_pct  = 45;
          rx_stall_pct = 29;
          // all-ones width clamps to the widest row; keep the frame short
          set_frame(511, 1, 1'b1, 1'b1);
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      if (phase != 2) send_frame(32'hFFFF_FFFF);
      phase_start = stream_items;

      while (stream_items - phase_start < PHASE_ITEMS) begin
        wval = ($urandom_range(99) < 5) ? $urandom_range(511) : $urandom_range(SMALL_SIDE);
        sel  = $urandom_range(3);
        // keep wide frames short: write both registers when width is large
        if (wval > SMALL_SIDE || eff_width() > SMALL_SIDE) sel = 2;
        hval = (wval > SMALL_SIDE) ? $urandom_range(3) : $urandom_range(10);
        set_frame(wval, hval, sel != 1, sel != 0);
        // a wide frame runs alone
        nframes = (eff_width() > SMALL_SIDE) ? 1 : $urandom_range(1, 3);
        cut     = 1'b0;
        for (f = 0; f < nframes && !cut; f++) begin
          span = eff_width() * eff_height() + eff_width() + 1;
          // a frame broken off is followed by a register write restart
          cut  = ($urandom_range(99) < 10);
          send_frame(cut ? $urandom_range(1, span - 1) : span);
          if (!cut && $urandom_range(99) < 15)
            push_item(MODE_FLUSH, pixel_t'($urandom_range(255)), 1'b0, '0, 1'b0);
        end
      end
    end

    // Tall frame: all-ones height clamps to the maximum row count; send
    // its first rows only.
    set_frame(3, 8191, 1'b1, 1'b1);
    send_frame(TALL_ITEMS);

    settle();
    if (mismatch_count == 0) begin
      $display("blur_3x3_center_weighted: match");
    end else begin
      $display("blur_3x3_center_weighted: mismatch");
    end
    $finish;
  end

endmodule

>>> blur_3x3_center_weighted.f
design/b3cw_pkg.sv
design/b3cw_cell.sv
design/b3cw_line.sv
design/b3cw_window.sv
design/blur_3x3_center_weighted.sv
tb/testbench.sv
